// ===== rtl/core/fuzzy_subsequence_scorer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer: assertion macros
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FUZZY_SUBSEQUENCE_SCORER_UNIT_MACROS_SVH
`define FUZZY_SUBSEQUENCE_SCORER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define FSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// condition must never be seen
`define FSS_NEVER(lbl, cond, msg) \
    `FSS_ASSERT(lbl, !(cond), msg)
`else
`define FSS_ASSERT(lbl, prop, msg)
`define FSS_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/core/fss_pkg.sv =====
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer: shared package
// Sizes, codes, beat and weight types and character helpers.
// ----------------------------------------------------------------------------
package fss_pkg;

    // sizes
    localparam int MAX_QUERY     = 64;
    localparam int QADDR_W       = $clog2(MAX_QUERY);
    localparam int QLEN_W        = $clog2(MAX_QUERY + 1);
    localparam int MAX_CANDIDATE = 4096;
    localparam int POS_W         = 12;
    localparam int POSX_W        = POS_W + 1;
    localparam int DIFF_W        = POS_W + 2;
    localparam int CHAR_W        = 8;
    localparam int WEIGHT_W      = 9;
    localparam int PROD_W        = DIFF_W + WEIGHT_W;
    localparam int SCORE_W       = 24;
    localparam int RUN_W         = 26;
    localparam int CFG_IDX_W     = 3;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);
    localparam int TDATA_IN_W    = 8;
    localparam int TDATA_OUT_W   = 40;

    localparam logic signed [RUN_W-1:0] SCORE_MAX = RUN_W'((1 << SCORE_W) - 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONSEC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAMEL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 3'd6;

    // weight reset values
    localparam logic signed [WEIGHT_W-1:0] RST_BASE   = 9'sd16;
    localparam logic signed [WEIGHT_W-1:0] RST_CONSEC = 9'sd15;
    localparam logic signed [WEIGHT_W-1:0] RST_GAP    = -9'sd1;
    localparam logic signed [WEIGHT_W-1:0] RST_BOUND  = 9'sd10;
    localparam logic signed [WEIGHT_W-1:0] RST_CAMEL  = 9'sd8;
    localparam logic signed [WEIGHT_W-1:0] RST_PREFIX = 9'sd12;
    localparam logic signed [WEIGHT_W-1:0] RST_TAIL   = -9'sd1;

    // characters
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFS  = 8'h20;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_CAND   = 2'd2
    } t_action;

    // classified beat between front and back
    typedef struct packed {
        t_action           action;
        logic [CHAR_W-1:0] fchar;
        logic              is_up;
        logic              is_low;
        logic              is_sep;
        logic              last;
    } t_item;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] base;
        logic signed [WEIGHT_W-1:0] consec;
        logic signed [WEIGHT_W-1:0] gap;
        logic signed [WEIGHT_W-1:0] bound;
        logic signed [WEIGHT_W-1:0] camel;
        logic signed [WEIGHT_W-1:0] prefix;
        logic signed [WEIGHT_W-1:0] tail;
    } t_weights;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic               matched;
        logic               is_last;
        logic [SCORE_W-1:0] score;
        logic               exact;
        logic               overflow;
    } t_result;

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= CH_UP_A) && (c <= CH_UP_Z);
    endfunction

    function automatic logic is_lower(input logic [CHAR_W-1:0] c);
        return (c >= CH_LO_A) && (c <= CH_LO_Z);
    endfunction

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        return is_upper(c) ? c + CASE_OFS : c;
    endfunction

    function automatic logic is_separator(input logic [CHAR_W-1:0] c);
        return c inside {CH_SPACE, CH_UNDER, CH_DASH, CH_DOT, CH_SLASH,
                         CH_BSLASH, CH_LPAREN, CH_LBRACK, CH_LBRACE};
    endfunction

    // clamp a running value into lo .. SCORE_MAX
    function automatic logic [SCORE_W-1:0] clamp_score(
        input logic signed [RUN_W-1:0] v,
        input logic signed [RUN_W-1:0] lo
    );
        logic signed [RUN_W-1:0] r;
        r = v;
        if (v < lo) begin
            r = lo;
        end else if (v > SCORE_MAX) begin
            r = SCORE_MAX;
        end
        return r[SCORE_W-1:0];
    endfunction

endpackage

// ===== rtl/core/fss_ram.sv =====
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer: generic RAM
// One write port, one read port, registered read, write data forwarded
// when read and write hit the same address.
// ----------------------------------------------------------------------------
module fss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, write-first on a collision
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fss_front.sv =====
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer: front end
// Takes input beats, drops unused actions, folds case and tags character
// classes before the beat goes into the queue.
// ----------------------------------------------------------------------------
module fss_front (
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [fss_pkg::TDATA_IN_W-1:0]    i_data,
    input  logic [1:0]                        i_user,
    input  logic                              i_last,
    input  logic                              i_queue_full,
    output logic                              o_push,
    output fss_pkg::t_item                    o_item
);

    logic known;

    // ready only follows queue space
    assign o_ready = !i_queue_full;

    assign known = (i_user == fss_pkg::ACT_CLEAR) || (i_user == fss_pkg::ACT_APPEND) ||
                   (i_user == fss_pkg::ACT_CAND);
    assign o_push = i_valid && o_ready && known;

    // classify the character
    always_comb begin
        o_item.action = fss_pkg::t_action'(i_user);
        o_item.fchar  = fss_pkg::fold(i_data[fss_pkg::CHAR_W-1:0]);
        o_item.is_up  = fss_pkg::is_upper(i_data[fss_pkg::CHAR_W-1:0]);
        o_item.is_low = fss_pkg::is_lower(i_data[fss_pkg::CHAR_W-1:0]);
        o_item.is_sep = fss_pkg::is_separator(i_data[fss_pkg::CHAR_W-1:0]);
        o_item.last   = i_last;
    end

endmodule

// ===== rtl/core/fss_queue.sv =====
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer: item queue
// Short FIFO of classified beats between front and back.
// ----------------------------------------------------------------------------
`include "fuzzy_subsequence_scorer_unit_macros.svh"

module fss_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fss_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output fss_pkg::t_item o_item
);

    fss_pkg::t_item                  r_mem [fss_pkg::QDEPTH];
    logic [fss_pkg::QPTR_W-1:0]      r_wr;
    logic [fss_pkg::QPTR_W-1:0]      r_rd;
    logic [fss_pkg::QCNT_W-1:0]      r_cnt;
    logic                            do_pop;

    assign o_full  = (r_cnt == fss_pkg::QCNT_W'(fss_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `FSS_NEVER(a_push_when_full, i_push && o_full, "queue push while full")
    `FSS_ASSERT(a_cnt_bound, r_cnt <= fss_pkg::QCNT_W'(fss_pkg::QDEPTH), "queue count over depth")

endmodule

// ===== rtl/core/fss_back.sv =====
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer: back end
// Holds the query and the candidate state, scores one candidate character
// per cycle while the output register is free to take its result, and keeps the result beat in that register.
// ----------------------------------------------------------------------------
`include "fuzzy_subsequence_scorer_unit_macros.svh"

module fss_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fss_pkg::t_weights i_w,
    input  logic              i_item_valid,
    input  fss_pkg::t_item    i_item,
    output logic              o_pop,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output fss_pkg::t_result  o_res
);

    // query and candidate state
    logic [fss_pkg::QLEN_W-1:0]       r_qlen, n_qlen;
    logic                             r_ovf, n_ovf;
    logic [fss_pkg::QLEN_W-1:0]       r_qi, n_qi;
    logic [fss_pkg::POS_W-1:0]        r_pos, n_pos;
    logic                             r_have, n_have;
    logic [fss_pkg::POS_W-1:0]        r_lm, n_lm;
    logic                             r_prev_low, n_prev_low;
    logic                             r_prev_sep, n_prev_sep;
    logic signed [fss_pkg::RUN_W-1:0] r_run, n_run;
    logic                             r_exact, n_exact;
    logic                             r_toolong, n_toolong;

    logic                             r_out_valid;
    fss_pkg::t_result                 r_out;

    logic [fss_pkg::CHAR_W-1:0]       q_at_qi;
    logic [fss_pkg::CHAR_W-1:0]       q_at_pos;
    logic                             ram_we;
    logic [fss_pkg::QADDR_W-1:0]      raddr_qi;
    logic [fss_pkg::QADDR_W-1:0]      raddr_pos;

    logic                             out_free;
    logic                             is_cand;
    logic                             match;
    logic                             pos_nz;
    logic                             camel;
    logic                             boundary;
    logic                             consec;
    logic                             exact_step;
    logic                             full_match;
    logic                             exact_final;
    logic [fss_pkg::QLEN_W-1:0]       qi_new;
    logic signed [fss_pkg::DIFF_W-1:0]   gap_diff;
    logic signed [fss_pkg::DIFF_W-1:0]   tail_diff;
    logic signed [fss_pkg::WEIGHT_W-1:0] w_gap;
    logic signed [fss_pkg::WEIGHT_W-1:0] w_tail;
    logic signed [fss_pkg::PROD_W-1:0]   gap_prod;
    logic signed [fss_pkg::PROD_W-1:0]   tail_prod;
    logic signed [fss_pkg::RUN_W-1:0]    incr;
    logic signed [fss_pkg::RUN_W-1:0]    run_new;
    logic signed [fss_pkg::RUN_W-1:0]    tail_total;
    logic signed [fss_pkg::RUN_W-1:0]    exact_val;
    logic [fss_pkg::SCORE_W-1:0]         score;

    // pop when the beat gives no result or the output register frees up
    assign out_free = !r_out_valid || i_res_ready;
    assign is_cand  = (i_item.action == fss_pkg::ACT_CAND);
    assign o_pop    = i_item_valid && (!is_cand || out_free);

    // two copies of the query: one read at the query index, one at the position
    assign ram_we    = o_pop && (i_item.action == fss_pkg::ACT_APPEND) &&
                       (r_qlen < fss_pkg::QLEN_W'(fss_pkg::MAX_QUERY));
    assign raddr_qi  = i_rst_n ? n_qi[fss_pkg::QADDR_W-1:0] : '0;
    assign raddr_pos = i_rst_n ? n_pos[fss_pkg::QADDR_W-1:0] : '0;

    fss_ram #(
        .WIDTH (fss_pkg::CHAR_W),
        .DEPTH (fss_pkg::MAX_QUERY)
    ) u_ram_qi (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_qlen[fss_pkg::QADDR_W-1:0]),
        .i_wdata (i_item.fchar),
        .i_raddr (raddr_qi),
        .o_rdata (q_at_qi)
    );

    fss_ram #(
        .WIDTH (fss_pkg::CHAR_W),
        .DEPTH (fss_pkg::MAX_QUERY)
    ) u_ram_pos (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_qlen[fss_pkg::QADDR_W-1:0]),
        .i_wdata (i_item.fchar),
        .i_raddr (raddr_pos),
        .o_rdata (q_at_pos)
    );

    // match and bonus terms
    assign match    = is_cand && (r_qi < r_qlen) && (i_item.fchar == q_at_qi);
    assign pos_nz   = (r_pos != '0);
    assign camel    = pos_nz && r_prev_low && i_item.is_up;
    assign boundary = !pos_nz || r_prev_sep || camel;
    assign consec   = ({1'b0, r_pos} == ({1'b0, r_lm} + fss_pkg::POSX_W'(1)));

    assign w_gap     = i_w.gap;
    assign w_tail    = i_w.tail;
    assign gap_diff  = $signed({2'b00, r_pos}) - $signed({2'b00, r_lm}) -
                       fss_pkg::DIFF_W'(1);
    assign tail_diff = $signed({2'b00, r_pos}) - $signed({2'b00, r_lm});
    assign gap_prod  = gap_diff * w_gap;
    assign tail_prod = tail_diff * w_tail;

    always_comb begin
        incr = fss_pkg::RUN_W'(i_w.base);
        if (r_have) begin
            incr = incr + (consec ? fss_pkg::RUN_W'(i_w.consec) : fss_pkg::RUN_W'(gap_prod));
        end
        if (boundary) begin
            incr = incr + fss_pkg::RUN_W'(i_w.bound);
        end
        if (camel) begin
            incr = incr + fss_pkg::RUN_W'(i_w.camel);
        end
        if ((r_qi == '0) && !pos_nz) begin
            incr = incr + fss_pkg::RUN_W'(i_w.prefix);
        end
    end

    assign run_new    = r_run + incr;
    assign tail_total = r_run + fss_pkg::RUN_W'(tail_prod);
    assign qi_new     = r_qi + fss_pkg::QLEN_W'(match);

    // exact-match tracking
    assign exact_step  = r_exact && !r_toolong &&
                         (r_pos < fss_pkg::POS_W'(r_qlen)) && (i_item.fchar == q_at_pos);
    assign full_match  = (r_qlen != '0) && (qi_new == r_qlen);
    assign exact_final = exact_step &&
                         (({1'b0, r_pos} + fss_pkg::POSX_W'(1)) == fss_pkg::POSX_W'(r_qlen));
    assign exact_val   = fss_pkg::RUN_W'($signed({1'b0, r_qlen}) * i_w.base) +
                         fss_pkg::RUN_W'(i_w.prefix) + fss_pkg::RUN_W'(i_w.prefix);

    // final score
    always_comb begin
        score = '0;
        if (i_item.last && full_match) begin
            if (exact_final) begin
                score = fss_pkg::clamp_score(exact_val, '0);
            end else begin
                score = fss_pkg::clamp_score(match ? run_new : tail_total,
                                             fss_pkg::RUN_W'(1));
            end
        end
    end

    // next state
    always_comb begin
        n_qlen     = r_qlen;
        n_ovf      = r_ovf;
        n_qi       = r_qi;
        n_pos      = r_pos;
        n_have     = r_have;
        n_lm       = r_lm;
        n_prev_low = r_prev_low;
        n_prev_sep = r_prev_sep;
        n_run      = r_run;
        n_exact    = r_exact;
        n_toolong  = r_toolong;
        if (o_pop) begin
            case (i_item.action)
                fss_pkg::ACT_CLEAR: begin
                    n_qlen = '0;
                    n_ovf  = 1'b0;
                end
                fss_pkg::ACT_APPEND: begin
                    if (r_qlen < fss_pkg::QLEN_W'(fss_pkg::MAX_QUERY)) begin
                        n_qlen = r_qlen + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                fss_pkg::ACT_CAND: begin
                    n_qi       = qi_new;
                    n_exact    = exact_step;
                    n_prev_low = i_item.is_low;
                    n_prev_sep = i_item.is_sep;
                    if (match) begin
                        n_run  = run_new;
                        n_have = 1'b1;
                        n_lm   = r_pos;
                    end
                    if (r_pos != fss_pkg::POS_W'(fss_pkg::MAX_CANDIDATE - 1)) begin
                        n_pos = r_pos + 1'b1;
                    end else begin
                        n_toolong = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            // any query change or a finished candidate restarts the candidate
            if (!is_cand || i_item.last) begin
                n_qi       = '0;
                n_pos      = '0;
                n_have     = 1'b0;
                n_lm       = '0;
                n_prev_low = 1'b0;
                n_prev_sep = 1'b0;
                n_run      = '0;
                n_exact    = 1'b1;
                n_toolong  = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen     <= '0;
            r_ovf      <= 1'b0;
            r_qi       <= '0;
            r_pos      <= '0;
            r_have     <= 1'b0;
            r_lm       <= '0;
            r_prev_low <= 1'b0;
            r_prev_sep <= 1'b0;
            r_run      <= '0;
            r_exact    <= 1'b1;
            r_toolong  <= 1'b0;
        end else begin
            r_qlen     <= n_qlen;
            r_ovf      <= n_ovf;
            r_qi       <= n_qi;
            r_pos      <= n_pos;
            r_have     <= n_have;
            r_lm       <= n_lm;
            r_prev_low <= n_prev_low;
            r_prev_sep <= n_prev_sep;
            r_run      <= n_run;
            r_exact    <= n_exact;
            r_toolong  <= n_toolong;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && is_cand) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_cand) begin
            r_out.position <= r_pos;
            r_out.matched  <= match;
            r_out.is_last  <= i_item.last;
            r_out.score    <= score;
            r_out.exact    <= i_item.last && full_match && exact_final;
            r_out.overflow <= r_ovf;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    `FSS_ASSERT(a_qi_in_query, r_qi <= r_qlen, "query index past query length")
    `FSS_ASSERT(a_qlen_cap, r_qlen <= fss_pkg::QLEN_W'(fss_pkg::MAX_QUERY), "query length over capacity")
    `FSS_ASSERT(a_last_restarts, (o_pop && is_cand && i_item.last) |=> ((r_pos == '0) && (r_qi == '0) && !r_have), "candidate not restarted after last beat")

endmodule

// ===== rtl/core/fuzzy_subsequence_scorer_unit.sv =====
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer: top level
// A candidate beat accepted on the input stream passes through a queue entry,
// then the output register, before it is on the result stream.
// Throughput: one beat per cycle while the result stream is not stalled, set by
// the score update in the back end; the four-entry queue absorbs short output stalls.
// Reset (synchronous, i_rst_n low): weights to defaults, query empty,
// queue and output empty. The query memory is not cleared and needs no pass.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fss_pkg::TDATA_IN_W-1:0]      s_axis_tdata,  // [7:0] char_in
    input  logic [1:0]                          s_axis_tuser,  // [1:0] action
    input  logic                                s_axis_tlast,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [11:0] position, [12] char_matched, [36:13] score, [37] exact_match,
    // [38] query_overflow, [39] zero
    output logic [fss_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    // weight registers
    input  logic                                i_cfg_we,
    input  logic [fss_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fss_pkg::WEIGHT_W-1:0]        i_cfg_data
);

    fss_pkg::t_weights r_w;
    fss_pkg::t_item    front_item;
    fss_pkg::t_item    queue_item;
    fss_pkg::t_result  res;
    logic              push;
    logic              queue_full;
    logic              queue_valid;
    logic              pop;

    // weight registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w.base   <= fss_pkg::RST_BASE;
            r_w.consec <= fss_pkg::RST_CONSEC;
            r_w.gap    <= fss_pkg::RST_GAP;
            r_w.bound  <= fss_pkg::RST_BOUND;
            r_w.camel  <= fss_pkg::RST_CAMEL;
            r_w.prefix <= fss_pkg::RST_PREFIX;
            r_w.tail   <= fss_pkg::RST_TAIL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fss_pkg::REG_BASE:   r_w.base   <= i_cfg_data;
                fss_pkg::REG_CONSEC: r_w.consec <= i_cfg_data;
                fss_pkg::REG_GAP:    r_w.gap    <= i_cfg_data;
                fss_pkg::REG_BOUND:  r_w.bound  <= i_cfg_data;
                fss_pkg::REG_CAMEL:  r_w.camel  <= i_cfg_data;
                fss_pkg::REG_PREFIX: r_w.prefix <= i_cfg_data;
                fss_pkg::REG_TAIL:   r_w.tail   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fss_front u_front (
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .i_user       (s_axis_tuser),
        .i_last       (s_axis_tlast),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_item       (front_item)
    );

    fss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    fss_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_w          (r_w),
        .i_item_valid (queue_valid),
        .i_item       (queue_item),
        .o_pop        (pop),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res        (res)
    );

    // result beat packing
    assign m_axis_tdata = {1'b0, res.overflow, res.exact, res.score, res.matched, res.position};
    assign m_axis_tlast = res.is_last;

endmodule

// ===== tb/fuzzy_subsequence_scorer_unit_test.sv =====
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer: unit test
// Drives query and candidate beats into the scorer and checks every result
// beat against a cycle-free score predictor held in a small scoreboard.
// Directed beats cover empty and unmatched queries, exact, boundary, camel,
// gap and tail scoring, query overflow and mid-candidate query changes.
// Random phases then run under several weight settings, with random stalls
// on both streams in every phase but the all-zero one.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer_unit_test;
    import fss_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 4;
    localparam int PHASE_LEN  = 270;
    localparam int WMAX       = 255;
    localparam int WMIN       = -256;

    // a few letters used by the directed beats
    localparam logic [CHAR_W-1:0] LO_B = CH_LO_A + 8'd1;
    localparam logic [CHAR_W-1:0] LO_C = CH_LO_A + 8'd2;
    localparam logic [CHAR_W-1:0] LO_Q = CH_LO_A + 8'd16;
    localparam logic [CHAR_W-1:0] LO_X = CH_LO_Z - 8'd2;
    localparam logic [CHAR_W-1:0] UP_B = CH_UP_A + 8'd1;
    localparam logic [CHAR_W-1:0] UP_C = CH_UP_A + 8'd2;

    // ------------------------------------------------------------------------
    // Score predictor and queue of expected result beats
    // ------------------------------------------------------------------------
    class match_score_board;
        int                weight [7];
        logic [CHAR_W-1:0] qchars [MAX_QUERY];
        int                qlen;
        int                qidx;
        int                cpos;
        int                last_hit;
        bit                has_hit;
        bit                overflow;
        bit                exact_ok;
        bit                too_long;
        logic [CHAR_W-1:0] prev_ch;
        longint            run_score;
        t_result           pending_scores [$];
        int                errors;

        function new();
            errors = 0;
            weight[REG_BASE]   = RST_BASE;
            weight[REG_CONSEC] = RST_CONSEC;
            weight[REG_GAP]    = RST_GAP;
            weight[REG_BOUND]  = RST_BOUND;
            weight[REG_CAMEL]  = RST_CAMEL;
            weight[REG_PREFIX] = RST_PREFIX;
            weight[REG_TAIL]   = RST_TAIL;
            qlen     = 0;
            overflow = 0;
            restart();
        endfunction

        function void restart();
            qidx      = 0;
            cpos      = 0;
            has_hit   = 0;
            last_hit  = 0;
            prev_ch   = '0;
            run_score = 0;
            exact_ok  = 1;
            too_long  = 0;
        endfunction

        function void set_weight(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] v);
            weight[idx] = $signed(v);
        endfunction

        function bit up_letter(logic [CHAR_W-1:0] c);
            return c >= CH_UP_A && c <= CH_UP_Z;
        endfunction

        function bit low_letter(logic [CHAR_W-1:0] c);
            return c >= CH_LO_A && c <= CH_LO_Z;
        endfunction

        function logic [CHAR_W-1:0] lowered(logic [CHAR_W-1:0] c);
            return up_letter(c) ? c + CASE_OFS : c;
        endfunction

        function bit word_break(logic [CHAR_W-1:0] c);
            case (c)
                CH_SPACE, CH_UNDER, CH_DASH, CH_DOT, CH_SLASH,
                CH_BSLASH, CH_LPAREN, CH_LBRACK, CH_LBRACE: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function longint clamp(longint v, longint lo);
            longint top;
            top = (longint'(1) << SCORE_W) - 1;
            if (v < lo) return lo;
            if (v > top) return top;
            return v;
        endfunction

        // update state for one accepted input beat, queue its result if any
        function void note_beat(logic [1:0] act, logic [CHAR_W-1:0] c, logic lst);
            int      pos;
            bit      hit;
            bit      camel;
            bit      bnd;
            bit      ex;
            longint  fin_score;
            t_result r;
            case (act)
                ACT_CLEAR: begin
                    qlen     = 0;
                    overflow = 0;
                    restart();
                end
                ACT_APPEND: begin
                    if (qlen < MAX_QUERY) begin
                        qchars[qlen] = c;
                        qlen++;
                    end else begin
                        overflow = 1;
                    end
                    restart();
                end
                ACT_CAND: begin
                    pos       = cpos;
                    hit       = 0;
                    ex        = 0;
                    fin_score = 0;
                    if (too_long || pos >= qlen) begin
                        exact_ok = 0;
                    end else if (lowered(c) != lowered(qchars[pos])) begin
                        exact_ok = 0;
                    end
                    // greedy match against the next open query character
                    if (qidx < qlen) begin
                        if (lowered(c) == lowered(qchars[qidx])) begin
                            hit   = 1;
                            camel = pos > 0 && low_letter(prev_ch) && up_letter(c);
                            bnd   = pos == 0 || word_break(prev_ch) || camel;
                            run_score += weight[REG_BASE];
                            if (has_hit) begin
                                if (pos == last_hit + 1) begin
                                    run_score += weight[REG_CONSEC];
                                end else begin
                                    run_score += longint'(pos - last_hit - 1) *
                                                 weight[REG_GAP];
                                end
                            end
                            if (bnd) run_score += weight[REG_BOUND];
                            if (camel) run_score += weight[REG_CAMEL];
                            if (qidx == 0 && pos == 0) run_score += weight[REG_PREFIX];
                            has_hit  = 1;
                            last_hit = pos;
                            qidx++;
                        end
                    end
                    // final score on the candidate's last character
                    if (lst && qlen > 0 && qidx == qlen) begin
                        if (exact_ok && pos + 1 == qlen) begin
                            ex = 1;
                            fin_score = clamp(longint'(qlen) * weight[REG_BASE] +
                                              2 * longint'(weight[REG_PREFIX]), 0);
                        end else begin
                            fin_score = clamp(run_score + longint'(pos - last_hit) *
                                              weight[REG_TAIL], 1);
                        end
                    end
                    r.position = pos[POS_W-1:0];
                    r.matched  = hit;
                    r.is_last  = lst;
                    r.score    = fin_score[SCORE_W-1:0];
                    r.exact    = ex;
                    r.overflow = overflow;
                    pending_scores.insert(pending_scores.size(), r);
                    if (lst) begin
                        restart();
                    end else begin
                        prev_ch = c;
                        if (cpos + 1 < MAX_CANDIDATE) cpos++;
                        else too_long = 1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare(string field, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        // check one accepted result beat against the oldest expectation
        function void check_beat(logic [TDATA_OUT_W-1:0] d, logic lst);
            t_result e;
            if (pending_scores.size() == 0) begin
                $error("result beat with nothing expected: tdata %h", d);
                errors++;
                return;
            end
            e = pending_scores.pop_front();
            compare("position", e.position, d[POS_W-1:0]);
            compare("char_matched", e.matched, d[POS_W]);
            compare("is_final", e.is_last, lst);
            compare("score", e.score, d[POS_W+1 +: SCORE_W]);
            compare("exact_match", e.exact, d[POS_W+1+SCORE_W]);
            compare("query_overflow", e.overflow, d[POS_W+2+SCORE_W]);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                       i_clk;
    logic                       i_rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [TDATA_IN_W-1:0]      s_axis_tdata;   // [7:0] char_in
    logic [1:0]                 s_axis_tuser;   // [1:0] action
    logic                       s_axis_tlast;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    // [11:0] position, [12] char_matched, [36:13] score, [37] exact_match,
    // [38] query_overflow, [39] zero
    logic [TDATA_OUT_W-1:0]     m_axis_tdata;
    logic                       m_axis_tlast;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_idx;
    logic [WEIGHT_W-1:0]        i_cfg_data;

    match_score_board  sb;
    bit                gaps_on;
    int                beats_sent;
    int                idle_cycles;
    logic [CHAR_W-1:0] query_text [$];

    fuzzy_subsequence_scorer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // result side stalls
    always @(posedge i_clk) begin
        if (gaps_on) begin
            m_axis_tready <= ($urandom_range(0, 99) >= 25);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // beat monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_beat(s_axis_tuser, s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_beat(m_axis_tdata, m_axis_tlast);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] word_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return CH_LO_A + CHAR_W'($urandom_range(0, 4));
        if (r < 60) return CH_UP_A + CHAR_W'($urandom_range(0, 4));
        if (r < 75) begin
            case ($urandom_range(0, 8))
                0: return CH_SPACE;
                1: return CH_UNDER;
                2: return CH_DASH;
                3: return CH_DOT;
                4: return CH_SLASH;
                5: return CH_BSLASH;
                6: return CH_LPAREN;
                7: return CH_LBRACK;
                default: return CH_LBRACE;
            endcase
        end
        // just inside and outside the letter ranges
        if (r < 85) begin
            case ($urandom_range(0, 5))
                0: return CH_UP_A - 8'd1;
                1: return CH_UP_Z;
                2: return CH_UP_Z + 8'd1;
                3: return CH_LO_A - 8'd1;
                4: return CH_LO_Z;
                default: return CH_LO_Z + 8'd1;
            endcase
        end
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CHAR_W-1:0] flip_case(input logic [CHAR_W-1:0] c);
        if ($urandom_range(0, 1)) return c;
        if (c >= CH_UP_A && c <= CH_UP_Z) return c + CASE_OFS;
        if (c >= CH_LO_A && c <= CH_LO_Z) return c - CASE_OFS;
        return c;
    endfunction

    // one input beat; returns on the edge that accepts it
    task automatic send_beat(input logic [1:0] act, input logic [CHAR_W-1:0] ch,
                             input logic lst);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 25) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= act;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // generator-side copy of the query
        if (act == ACT_CLEAR) begin
            query_text.delete();
        end else if (act == ACT_APPEND && query_text.size() < MAX_QUERY) begin
            query_text.insert(query_text.size(), ch);
        end
        if (act != ACT_UNUSED) beats_sent++;
    endtask

    task automatic new_query(input int len);
        send_beat(ACT_CLEAR, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        repeat (len) send_beat(ACT_APPEND, word_char(), 1'($urandom_range(0, 1)));
    endtask

    // candidate mixing query characters with noise; close marks the end
    task automatic send_candidate(input int len, input bit close);
        int k;
        int j;
        logic [CHAR_W-1:0] c;
        j = 0;
        for (k = 0; k < len; k++) begin
            if (j < query_text.size() && $urandom_range(0, 99) < 55) begin
                c = flip_case(query_text[j]);
                j++;
            end else begin
                c = word_char();
            end
            send_beat(ACT_CAND, c, close && k == len - 1);
        end
    endtask

    // candidate equal to the query up to case, or one random character for an empty query
    task automatic send_copy();
        int k;
        int n;
        n = query_text.size();
        if (n == 0) begin
            send_beat(ACT_CAND, word_char(), 1'b1);
        end else begin
            for (k = 0; k < n; k++) send_beat(ACT_CAND, flip_case(query_text[k]), k == n - 1);
        end
    endtask

    // hold the sender until every expected result beat is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_scores.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_weight(input logic [CFG_IDX_W-1:0] idx, input int v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v[WEIGHT_W-1:0];
        @(posedge i_clk);
        sb.set_weight(idx, v[WEIGHT_W-1:0]);
    endtask

    task automatic program_weights(input int base, input int consec, input int gap,
                                   input int bound, input int camel, input int prefix,
                                   input int tail);
        settle();
        load_weight(REG_BASE, base);
        load_weight(REG_CONSEC, consec);
        load_weight(REG_GAP, gap);
        load_weight(REG_BOUND, bound);
        load_weight(REG_CAMEL, camel);
        load_weight(REG_PREFIX, prefix);
        load_weight(REG_TAIL, tail);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int any_weight();
        return int'($urandom_range(0, 511)) + WMIN;
    endfunction

    // mostly well-formed query/candidate traffic, some noise and pauses
    task automatic run_random(input int count);
        int target;
        int roll;
        int len;
        target = beats_sent + count;
        while (beats_sent < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                if ($urandom_range(0, 24) == 0) len = $urandom_range(MAX_QUERY - 4, MAX_QUERY + 6);
                else if ($urandom_range(0, 9) == 0) len = 0;
                else len = $urandom_range(1, 6);
                new_query(len);
            end else if (roll < 13) begin
                send_beat(ACT_APPEND, word_char(), 1'($urandom_range(0, 1)));
            end else if (roll < 16) begin
                send_beat(2'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end else if (roll < 17) begin
                wait_drained();
            end else if (roll < 27) begin
                send_copy();
            end else begin
                send_candidate($urandom_range(1, 12), $urandom_range(0, 99) < 95);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        gaps_on       = 1'b0;
        beats_sent    = 0;
        idle_cycles   = 0;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gaps_on = 1'b1;

        // directed: empty query, exact, boundary/camel, gap/tail, unmatched
        send_beat(ACT_CAND, LO_X, 1'b1);
        send_beat(ACT_CLEAR, 8'hFF, 1'b1);
        send_beat(ACT_APPEND, CH_LO_A, 1'b0);
        send_beat(ACT_APPEND, UP_B, 1'b0);
        send_beat(ACT_CAND, CH_UP_A, 1'b0);
        send_beat(ACT_CAND, LO_B, 1'b1);
        send_beat(ACT_CAND, LO_X, 1'b0);
        send_beat(ACT_CAND, CH_UNDER, 1'b0);
        send_beat(ACT_CAND, CH_LO_A, 1'b0);
        send_beat(ACT_CAND, UP_B, 1'b1);
        send_beat(ACT_CAND, CH_LO_A, 1'b0);
        send_beat(ACT_CAND, CH_LO_Z, 1'b0);
        send_beat(ACT_CAND, CH_LO_Z, 1'b0);
        send_beat(ACT_CAND, LO_B, 1'b0);
        send_beat(ACT_CAND, LO_Q, 1'b1);
        send_beat(ACT_CAND, LO_B, 1'b0);
        send_beat(ACT_CAND, CH_LO_A, 1'b1);
        send_beat(ACT_UNUSED, 8'h55, 1'b1);
        // extreme bytes in the query, then a query change mid-candidate
        send_beat(ACT_APPEND, 8'hFF, 1'b0);
        send_beat(ACT_APPEND, 8'h00, 1'b0);
        send_beat(ACT_CAND, CH_LO_A, 1'b0);
        send_beat(ACT_APPEND, LO_C, 1'b0);
        send_beat(ACT_CAND, CH_UP_A, 1'b0);
        send_beat(ACT_CAND, LO_B, 1'b0);
        send_beat(ACT_CAND, 8'hFF, 1'b0);
        send_beat(ACT_CAND, 8'h00, 1'b0);
        send_beat(ACT_CAND, UP_C, 1'b1);

        // query overflow, then a clear drops the flag
        new_query(MAX_QUERY + 2);
        send_candidate(3, 1'b1);
        send_copy();
        new_query(1);
        send_copy();

        // random phases under several weight settings
        program_weights(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX);
        run_random(PHASE_LEN);
        program_weights(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN);
        run_random(PHASE_LEN);
        program_weights(0, 0, 0, 0, 0, 0, 0);
        gaps_on = 1'b0;
        run_random(PHASE_LEN);
        gaps_on = 1'b1;
        program_weights(any_weight(), any_weight(), any_weight(), any_weight(),
                        any_weight(), any_weight(), any_weight());
        run_random(PHASE_LEN);
        program_weights(WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, WMAX);
        run_random(PHASE_LEN);
        program_weights(RST_BASE, RST_CONSEC, RST_GAP, RST_BOUND, RST_CAMEL,
                        RST_PREFIX, RST_TAIL);
        run_random(PHASE_LEN);

        settle();
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
